// ===== rtl/core/bep_pkg.sv =====
// Box erase pixel stream: shared constants, codes and the token carried
// along the cell chain. No dependencies.
`default_nettype none
package bep_pkg;

	localparam int MAX_BOXES       = 16;
	localparam int COORD_WIDTH     = 13;
	localparam int SAMPLE_WIDTH    = 8;
	localparam int POS_WIDTH       = 12;
	localparam int INDEX_WIDTH     = 4;
	localparam int NUM_BOXES_WIDTH = 5;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 13;
	localparam int CELL_ID_WIDTH   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_NUM_BOXES     = 3'd0,
		CFG_ROI_X         = 3'd1,
		CFG_ROI_Y         = 3'd2,
		CFG_ROI_WIDTH     = 3'd3,
		CFG_ROI_HEIGHT    = 3'd4,
		CFG_THREE_CHANNEL = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_LOAD  = 1'b1
	} req_t;

	typedef struct packed {
		logic                    valid;
		req_t                    req;
		logic [INDEX_WIDTH-1:0]  idx;
		logic [COORD_WIDTH-1:0]  left;
		logic [COORD_WIDTH-1:0]  top;
		logic [COORD_WIDTH-1:0]  right;
		logic [COORD_WIDTH-1:0]  bottom;
		logic [POS_WIDTH-1:0]    row;
		logic [POS_WIDTH-1:0]    col;
		logic [SAMPLE_WIDTH-1:0] c0;
		logic [SAMPLE_WIDTH-1:0] c1;
		logic [SAMPLE_WIDTH-1:0] c2;
		logic                    hit;
	} token_t;

	function automatic logic [COORD_WIDTH-1:0] clamp_range(
		input logic [COORD_WIDTH-1:0] v,
		input logic [COORD_WIDTH-1:0] lo,
		input logic [COORD_WIDTH-1:0] hi
	);
		logic [COORD_WIDTH-1:0] r;
		r = v;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bep_if.sv =====
// Box erase pixel stream: valid/ready channel interfaces for input items
// and results. Depends on bep_pkg.
`default_nettype none
interface bep_in_if;
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic [bep_pkg::INDEX_WIDTH-1:0]   box_index;
	logic [bep_pkg::COORD_WIDTH-1:0]   box_left;
	logic [bep_pkg::COORD_WIDTH-1:0]   box_top;
	logic [bep_pkg::COORD_WIDTH-1:0]   box_right;
	logic [bep_pkg::COORD_WIDTH-1:0]   box_bottom;
	logic [bep_pkg::POS_WIDTH-1:0]     pixel_row;
	logic [bep_pkg::POS_WIDTH-1:0]     pixel_col;
	logic [bep_pkg::SAMPLE_WIDTH-1:0]  chan0;
	logic [bep_pkg::SAMPLE_WIDTH-1:0]  chan1;
	logic [bep_pkg::SAMPLE_WIDTH-1:0]  chan2;

	modport source (output valid, req_type, box_index, box_left, box_top, box_right,
		box_bottom, pixel_row, pixel_col, chan0, chan1, chan2, input ready);
	modport sink (input valid, req_type, box_index, box_left, box_top, box_right,
		box_bottom, pixel_row, pixel_col, chan0, chan1, chan2, output ready);
endinterface

interface bep_out_if;
	logic                              valid;
	logic                              ready;
	logic [bep_pkg::SAMPLE_WIDTH-1:0]  out0;
	logic [bep_pkg::SAMPLE_WIDTH-1:0]  out1;
	logic [bep_pkg::SAMPLE_WIDTH-1:0]  out2;
	logic                              erased;

	modport source (output valid, out0, out1, out2, erased, input ready);
	modport sink (input valid, out0, out1, out2, erased, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bep_clamp.sv =====
// Box erase pixel stream: entry stage, clamps load corners to the region
// of interest and registers the token. Depends on bep_pkg.
`default_nettype none
module bep_clamp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             adv,
	input  wire bep_pkg::token_t                  tok_in,
	input  wire logic [bep_pkg::POS_WIDTH-1:0]    roi_x,
	input  wire logic [bep_pkg::POS_WIDTH-1:0]    roi_y,
	input  wire logic [bep_pkg::COORD_WIDTH-1:0]  roi_width,
	input  wire logic [bep_pkg::COORD_WIDTH-1:0]  roi_height,
	output bep_pkg::token_t                       tok_out
);
	logic                            valid_s1;
	bep_pkg::token_t                 tok_s1;
	bep_pkg::token_t                 nxt;
	logic [bep_pkg::COORD_WIDTH-1:0] lo_x;
	logic [bep_pkg::COORD_WIDTH-1:0] lo_y;

	assign lo_x = bep_pkg::COORD_WIDTH'(roi_x);
	assign lo_y = bep_pkg::COORD_WIDTH'(roi_y);

	always_comb begin
		nxt        = tok_in;
		nxt.left   = bep_pkg::clamp_range(tok_in.left, lo_x, roi_width);
		nxt.top    = bep_pkg::clamp_range(tok_in.top, lo_y, roi_height);
		nxt.right  = bep_pkg::clamp_range(tok_in.right, nxt.left, roi_width);
		nxt.bottom = bep_pkg::clamp_range(tok_in.bottom, nxt.top, roi_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1 <= nxt;
		end
	end

	always_comb begin
		tok_out       = tok_s1;
		tok_out.valid = valid_s1;
	end
endmodule
`default_nettype wire

// ===== rtl/core/bep_cell.sv =====
// Box erase pixel stream: one cell of the chain, holds one box entry,
// loads it or tests a passing pixel against it. Depends on bep_pkg.
`default_nettype none
module bep_cell (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               adv,
	input  wire logic                               active,
	input  wire logic [bep_pkg::CELL_ID_WIDTH-1:0]  cell_id,
	input  wire bep_pkg::token_t                    tok_in,
	output bep_pkg::token_t                         tok_out
);
	logic                             valid_q;
	bep_pkg::token_t                  tok_q;
	bep_pkg::token_t                  nxt;
	logic [bep_pkg::COORD_WIDTH-1:0]  left_q;
	logic [bep_pkg::COORD_WIDTH-1:0]  top_q;
	logic [bep_pkg::COORD_WIDTH-1:0]  right_q;
	logic [bep_pkg::COORD_WIDTH-1:0]  bottom_q;
	logic [bep_pkg::SAMPLE_WIDTH-1:0] col0_q;
	logic [bep_pkg::SAMPLE_WIDTH-1:0] col1_q;
	logic [bep_pkg::SAMPLE_WIDTH-1:0] col2_q;
	logic [bep_pkg::COORD_WIDTH-1:0]  row_x;
	logic [bep_pkg::COORD_WIDTH-1:0]  col_x;
	logic                             load_here;
	logic                             hit;

	assign row_x     = bep_pkg::COORD_WIDTH'(tok_in.row);
	assign col_x     = bep_pkg::COORD_WIDTH'(tok_in.col);
	assign load_here = tok_in.valid && (tok_in.req == bep_pkg::REQ_LOAD)
		&& (32'(tok_in.idx) == 32'(cell_id));
	assign hit       = tok_in.valid && (tok_in.req == bep_pkg::REQ_PIXEL) && active
		&& (row_x >= top_q) && (row_x <= bottom_q)
		&& (col_x >= left_q) && (col_x <= right_q);

	always_comb begin
		nxt = tok_in;
		if (hit) begin
			nxt.hit = 1'b1;
			nxt.c0  = col0_q;
			nxt.c1  = col1_q;
			nxt.c2  = col2_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= nxt;
			if (load_here) begin
				left_q   <= tok_in.left;
				top_q    <= tok_in.top;
				right_q  <= tok_in.right;
				bottom_q <= tok_in.bottom;
				col0_q   <= tok_in.c0;
				col1_q   <= tok_in.c1;
				col2_q   <= tok_in.c2;
			end
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end
endmodule
`default_nettype wire

// ===== rtl/core/box_erase_pixel_stream.sv =====
// Box erase pixel stream top level: configuration registers, clamp stage
// and a chain of MAX_BOXES box cells. Depends on bep_pkg, bep_if, bep_clamp, bep_cell.
// Pipeline: the clamp stage register, then one register per cell, from input transfer to result.
// Throughput: one item per cycle; the whole chain holds only while a result waits.
// Reset: configuration takes its reset values and the chain empties; the box
// table is undefined until loaded.
`default_nettype none
module box_erase_pixel_stream (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [bep_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire logic [bep_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	bep_in_if.sink                                    din,
	bep_out_if.source                                 dout
);
	logic [bep_pkg::NUM_BOXES_WIDTH-1:0] num_boxes_q;
	logic [bep_pkg::POS_WIDTH-1:0]       roi_x_q;
	logic [bep_pkg::POS_WIDTH-1:0]       roi_y_q;
	logic [bep_pkg::COORD_WIDTH-1:0]     roi_width_q;
	logic [bep_pkg::COORD_WIDTH-1:0]     roi_height_q;
	logic                                three_channel_q;

	bep_pkg::token_t                     raw;
	bep_pkg::token_t                     chain [0:bep_pkg::MAX_BOXES];
	bep_pkg::token_t                     last;
	logic [bep_pkg::MAX_BOXES-1:0]       active;
	logic                                adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_boxes_q     <= '0;
			roi_x_q         <= '0;
			roi_y_q         <= '0;
			roi_width_q     <= bep_pkg::COORD_WIDTH'(4096);
			roi_height_q    <= bep_pkg::COORD_WIDTH'(4096);
			three_channel_q <= 1'b1;
		end else if (cfg_we) begin
			case (bep_pkg::cfg_reg_t'(cfg_index))
				bep_pkg::CFG_NUM_BOXES: begin
					num_boxes_q <= cfg_data[bep_pkg::NUM_BOXES_WIDTH-1:0];
				end
				bep_pkg::CFG_ROI_X: begin
					roi_x_q <= cfg_data[bep_pkg::POS_WIDTH-1:0];
				end
				bep_pkg::CFG_ROI_Y: begin
					roi_y_q <= cfg_data[bep_pkg::POS_WIDTH-1:0];
				end
				bep_pkg::CFG_ROI_WIDTH: begin
					roi_width_q <= cfg_data[bep_pkg::COORD_WIDTH-1:0];
				end
				bep_pkg::CFG_ROI_HEIGHT: begin
					roi_height_q <= cfg_data[bep_pkg::COORD_WIDTH-1:0];
				end
				bep_pkg::CFG_THREE_CHANNEL: begin
					three_channel_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign last      = chain[bep_pkg::MAX_BOXES];
	assign adv       = !(last.valid && (last.req == bep_pkg::REQ_PIXEL) && !dout.ready);
	assign din.ready = adv;

	always_comb begin
		raw.valid  = din.valid;
		raw.req    = bep_pkg::req_t'(din.req_type);
		raw.idx    = din.box_index;
		raw.left   = din.box_left;
		raw.top    = din.box_top;
		raw.right  = din.box_right;
		raw.bottom = din.box_bottom;
		raw.row    = din.pixel_row;
		raw.col    = din.pixel_col;
		raw.c0     = din.chan0;
		raw.c1     = din.chan1;
		raw.c2     = din.chan2;
		raw.hit    = 1'b0;
	end

	bep_clamp u_clamp (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.tok_in     (raw),
		.roi_x      (roi_x_q),
		.roi_y      (roi_y_q),
		.roi_width  (roi_width_q),
		.roi_height (roi_height_q),
		.tok_out    (chain[0])
	);

	for (genvar k = 0; k < bep_pkg::MAX_BOXES; k++) begin : g_cell
		assign active[k] = (32'(num_boxes_q) > 32'(k));

		bep_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.active  (active[k]),
			.cell_id (bep_pkg::CELL_ID_WIDTH'(k)),
			.tok_in  (chain[k]),
			.tok_out (chain[k+1])
		);
	end

	assign dout.valid  = last.valid && (last.req == bep_pkg::REQ_PIXEL);
	assign dout.out0   = last.c0;
	assign dout.out1   = three_channel_q ? last.c1 : '0;
	assign dout.out2   = three_channel_q ? last.c2 : '0;
	assign dout.erased = last.hit;
endmodule
`default_nettype wire
